>>> design/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor writer package
// Shared types, register codes and limits of the console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam logic [7:0] MAX_COLUMNS   = 8'd128;
    localparam logic [6:0] MAX_ROWS      = 7'd64;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd24;
    localparam logic [4:0] TAB_RESET     = 5'd8;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAB     = 2'd2;

    localparam logic [7:0]  CHAR_TAB       = 8'h09;
    localparam logic [7:0]  CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0]  CHAR_RETURN    = 8'h0D;
    localparam logic [7:0]  CHAR_PRINT_LOW = 8'h20;
    localparam logic [7:0]  CHAR_IGNORED   = 8'hFF;
    localparam logic [15:0] CELL_ATTRIBUTE = 16'h0700;

    localparam int unsigned DIV_W     = 8;
    localparam int unsigned DIV_STEPS = DIV_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COL_MOD,
        ST_TAB_MOD,
        ST_TAB_WRAP,
        ST_ROW_MOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

>>> design/tccw_divider.sv
// ----------------------------------------------------------------------------
// Console cursor writer remainder unit
// Restoring shift-subtract unit that returns dividend modulo divisor, one
// bit per cycle.
// ----------------------------------------------------------------------------
module tccw_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  tccw_pkg::div_req_t req,
    output tccw_pkg::div_rsp_t rsp
);
    import tccw_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     dvd_next;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W-1:0]     dvs_next;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_W:0]       trial;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("Remainder is not below the divisor.");

    a_start_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("Division start did not make the unit busy.");

    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("Unit left busy without a done pulse.");

endmodule

>>> design/tccw_control.sv
// ----------------------------------------------------------------------------
// Console cursor writer sequencer
// Decodes each character, steps the cursor through the shared remainder
// unit and holds the finished result word in the output register.
// ----------------------------------------------------------------------------
module tccw_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               write_enable,
    output logic [12:0]        cell_address,
    output logic [15:0]        cell_value,
    output logic [5:0]         cursor_row_out,
    output logic [6:0]         cursor_col_out,
    input  logic [7:0]         cols,
    input  logic [6:0]         rows,
    input  logic [4:0]         tab,
    output tccw_pkg::div_req_t div_req,
    input  tccw_pkg::div_rsp_t div_rsp
);
    import tccw_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [7:0]  code_reg;
    logic [7:0]  code_next;
    logic [5:0]  row_reg;
    logic [5:0]  row_next;
    logic [6:0]  col_reg;
    logic [6:0]  col_next;
    logic [12:0] addr_reg;
    logic [12:0] addr_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        we_reg;
    logic        we_next;
    logic [12:0] out_addr_reg;
    logic [12:0] out_addr_next;
    logic [15:0] out_val_reg;
    logic [15:0] out_val_next;
    logic [5:0]  out_row_reg;
    logic [5:0]  out_row_next;
    logic [6:0]  out_col_reg;
    logic [6:0]  out_col_next;

    logic        is_print;
    logic        out_free;
    logic [13:0] addr_full;
    logic [7:0]  tab_col;
    logic [7:0]  row_inc;

    assign is_print  = (code_reg >= CHAR_PRINT_LOW) && (code_reg != CHAR_IGNORED);
    assign out_free  = !out_valid_reg || out_ready;
    assign addr_full = 14'(row_reg) * 14'(cols) + 14'(col_reg);
    assign tab_col   = 8'({1'b0, col_reg} + {3'b000, tab} - div_rsp.rem);
    assign row_inc   = 8'({2'b00, row_reg} + 8'd1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (is_print)
                begin
                    state_next = ST_COL_MOD;
                end
                else if (code_reg == CHAR_NEWLINE)
                begin
                    state_next = ST_ROW_MOD;
                end
                else if (code_reg == CHAR_TAB)
                begin
                    state_next = ST_TAB_MOD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COL_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_rsp.rem == '0) ? ST_ROW_MOD : ST_DONE;
                end
            end
            ST_TAB_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = (tab_col >= cols) ? ST_TAB_WRAP : ST_DONE;
                end
            end
            ST_TAB_WRAP:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_ROW_MOD;
                end
            end
            ST_ROW_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        code_next      = code_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        div_req        = '0;
        out_valid_next = out_valid_reg && !out_ready;
        we_next        = we_reg;
        out_addr_next  = out_addr_reg;
        out_val_next   = out_val_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    code_next = char_code;
                end
            end
            ST_DECODE:
            begin
                addr_next = addr_full[12:0];
                if (is_print)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 8'({1'b0, col_reg} + 8'd1);
                    div_req.divisor  = cols;
                end
                else if (code_reg == CHAR_NEWLINE)
                begin
                    col_next         = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = row_inc;
                    div_req.divisor  = {1'b0, rows};
                end
                else if (code_reg == CHAR_RETURN)
                begin
                    col_next = '0;
                end
                else if (code_reg == CHAR_TAB)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, col_reg};
                    div_req.divisor  = {3'b000, tab};
                end
            end
            ST_COL_MOD:
            begin
                if (div_rsp.done)
                begin
                    col_next = div_rsp.rem[6:0];
                    if (div_rsp.rem == '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = row_inc;
                        div_req.divisor  = {1'b0, rows};
                    end
                end
            end
            ST_TAB_MOD:
            begin
                if (div_rsp.done)
                begin
                    if (tab_col >= cols)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = tab_col;
                        div_req.divisor  = cols;
                    end
                    else
                    begin
                        col_next = tab_col[6:0];
                    end
                end
            end
            ST_TAB_WRAP:
            begin
                if (div_rsp.done)
                begin
                    col_next         = div_rsp.rem[6:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = row_inc;
                    div_req.divisor  = {1'b0, rows};
                end
            end
            ST_ROW_MOD:
            begin
                if (div_rsp.done)
                begin
                    row_next = div_rsp.rem[5:0];
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    we_next        = is_print;
                    out_addr_next  = is_print ? addr_reg : '0;
                    out_val_next   = is_print ? (CELL_ATTRIBUTE | {8'h00, code_reg}) : '0;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                end
            end
            default:
            begin
                code_next = code_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        addr_reg     <= addr_next;
        we_reg       <= we_next;
        out_addr_reg <= out_addr_next;
        out_val_reg  <= out_val_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign write_enable   = we_reg;
    assign cell_address   = out_addr_reg;
    assign cell_value     = out_val_reg;
    assign cursor_row_out = out_row_reg;
    assign cursor_col_out = out_col_reg;

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Sequencer took a second word while working.");

    a_start_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("Division started while the unit was busy.");

    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (out_valid_reg && in_ready))
        else $error("Finished word was not loaded into the output register.");

endmodule

>>> design/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// Text console cursor writer
// Keeps a row and column cursor on a text screen and turns each character
// word into a cell write and the updated cursor position.
// ----------------------------------------------------------------------------
// Usage: character words enter on in_valid/in_ready with char_code; one
// result word per character leaves on out_valid/out_ready carrying the
// write enable, cell address, cell value and the cursor after the character.
// Screen size and tab spacing are set through cfg_wr_en, cfg_index and
// cfg_data; the user must do so only while the block is idle, as the
// block itself does not enforce it.
// Return and ignored codes go from decode straight to the result word;
// printable characters, newlines and tabs step the cursor through the
// shared remainder unit, which takes one modulo at a time and is used up
// to three times per word, the most for a tab that wraps the line.
// The block takes one word at a time; it is ready again once the result
// stands in the output register, even while that word waits to be taken.
// Reset clears the cursor to row 0, column 0, drops any pending result and
// loads 80 columns, 24 rows and a tab spacing of 8.
// A stalled receiver holds the output word; a following character is then
// worked on but stays in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module text_console_cursor_writer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           char_code,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 write_enable,
    output logic [12:0]                          cell_address,
    output logic [15:0]                          cell_value,
    output logic [5:0]                           cursor_row_out,
    output logic [6:0]                           cursor_col_out,
    input  logic                                 cfg_wr_en,
    input  logic [tccw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tccw_pkg::*;

    logic [7:0] columns_reg;
    logic [7:0] columns_next;
    logic [6:0] rows_reg;
    logic [6:0] rows_next;
    logic [4:0] tab_reg;
    logic [4:0] tab_next;
    logic [7:0] cols_eff;
    logic [6:0] rows_eff;
    logic [4:0] tab_eff;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        tab_next     = tab_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COLUMNS: columns_next = cfg_data;
                CFG_ROWS:    rows_next    = cfg_data[6:0];
                CFG_TAB:     tab_next     = cfg_data[4:0];
                default:     columns_next = columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            tab_reg     <= TAB_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            tab_reg     <= tab_next;
        end
    end

    // A zero setting counts as one, and oversize screens saturate.
    always_comb
    begin
        if (columns_reg == '0)
        begin
            cols_eff = 8'd1;
        end
        else if (columns_reg > MAX_COLUMNS)
        begin
            cols_eff = MAX_COLUMNS;
        end
        else
        begin
            cols_eff = columns_reg;
        end
        if (rows_reg == '0)
        begin
            rows_eff = 7'd1;
        end
        else if (rows_reg > MAX_ROWS)
        begin
            rows_eff = MAX_ROWS;
        end
        else
        begin
            rows_eff = rows_reg;
        end
        tab_eff = (tab_reg == '0) ? 5'd1 : tab_reg;
    end

    tccw_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    tccw_control u_control (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_enable   (write_enable),
        .cell_address   (cell_address),
        .cell_value     (cell_value),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cols           (cols_eff),
        .rows           (rows_eff),
        .tab            (tab_eff),
        .div_req        (div_req),
        .div_rsp        (div_rsp)
    );

endmodule
